>>> hw/rtl/mtfl_pkg.sv
package mtfl_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int ID_W       = 30;
    localparam int POS_W      = 6;
    localparam int LCNT_W     = 7;
    localparam int ACT_W      = 2;
    localparam int IDX_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [ACT_W-1:0] ACT_TOUCH = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ID_W-1:0]   wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } store_req_t;

    typedef struct packed {
        logic              evicted;
        logic              was_present;
        logic [LCNT_W-1:0] list_count;
        logic              entry_valid;
        logic [ID_W-1:0]   entry_id;
    } result_t;

endpackage

>>> hw/rtl/mtfl_store.sv
module mtfl_store
(
    input  logic                       clk,
    input  mtfl_pkg::store_req_t       req,
    output logic [mtfl_pkg::ID_W-1:0]  rdata
);

    logic [mtfl_pkg::ID_W-1:0] mem [mtfl_pkg::LIST_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

>>> hw/rtl/move_to_front_recency_list_core.sv
// Move-to-front recency list of up to LIST_DEPTH distinct 30-bit ids, most recent at position 0,
// held in one single-port-style memory and walked by one comparator. A touch scans from the
// front, rippling each entry one place back, until it meets the id or the end of the list:
// each entry scanned takes a registered memory read, then a compare and write back. One
// request is in work at a time; a finished result sits in an output register while the next
// request is taken. A touch of a new id into a full list drops the least recent entry and
// reports evicted.
module move_to_front_recency_list_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // action[1:0], session_id[31:2], position[37:32], zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // entry_id, entry_valid, list_count, was_present, evicted
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [mtfl_pkg::ACT_W-1:0]      op_reg, op_next;
    logic [mtfl_pkg::ID_W-1:0]       key_reg, key_next;
    logic [mtfl_pkg::ID_W-1:0]       carry_reg, carry_next;
    logic [mtfl_pkg::CNT_W-1:0]      idx_reg, idx_next;
    logic [mtfl_pkg::CNT_W-1:0]      count_reg, count_next;
    mtfl_pkg::result_t               res_reg, res_next;
    mtfl_pkg::result_t               out_reg, out_next;
    logic                            out_valid_reg, out_valid_next;

    mtfl_pkg::store_req_t            store_req;
    logic [mtfl_pkg::ID_W-1:0]       rd_data;

    logic [mtfl_pkg::ACT_W-1:0]      in_action;
    logic [mtfl_pkg::ID_W-1:0]       in_id;
    logic [mtfl_pkg::POS_W-1:0]      in_pos;
    logic                            accept;
    logic                            out_free;
    logic                            pos_ok;

    assign in_action = s_axis_tdata[1:0];
    assign in_id     = s_axis_tdata[31:2];
    assign in_pos    = s_axis_tdata[37:32];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign pos_ok        = mtfl_pkg::IDX_W'(in_pos) < mtfl_pkg::IDX_W'(count_reg);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    mtfl_store u_store
    (
        .clk   (clk),
        .req   (store_req),
        .rdata (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        carry_next     = carry_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        store_req      = '0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = in_action;
                    key_next   = in_id;
                    carry_next = in_id;
                    res_next   = '0;
                    res_next.list_count = mtfl_pkg::LCNT_W'(count_reg);
                    case (in_action)
                        mtfl_pkg::ACT_TOUCH:
                        begin
                            idx_next   = '0;
                            state_next = ST_FETCH;
                        end
                        mtfl_pkg::ACT_READ:
                        begin
                            idx_next   = mtfl_pkg::CNT_W'(in_pos);
                            state_next = pos_ok ? ST_FETCH : ST_DONE;
                        end
                        mtfl_pkg::ACT_CLEAR:
                        begin
                            count_next          = '0;
                            res_next.list_count = '0;
                            state_next          = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                if (op_reg == mtfl_pkg::ACT_TOUCH && idx_reg == count_reg)
                begin
                    if (count_reg == mtfl_pkg::CNT_W'(mtfl_pkg::LIST_DEPTH))
                    begin
                        res_next.evicted = 1'b1;
                    end
                    else
                    begin
                        store_req.we        = 1'b1;
                        store_req.waddr     = idx_reg[mtfl_pkg::ADDR_W-1:0];
                        store_req.wdata     = carry_reg;
                        count_next          = count_reg + 1'b1;
                        res_next.list_count = mtfl_pkg::LCNT_W'(count_reg + 1'b1);
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    store_req.re    = 1'b1;
                    store_req.raddr = idx_reg[mtfl_pkg::ADDR_W-1:0];
                    state_next      = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (op_reg == mtfl_pkg::ACT_TOUCH)
                begin
                    store_req.we    = 1'b1;
                    store_req.waddr = idx_reg[mtfl_pkg::ADDR_W-1:0];
                    store_req.wdata = carry_reg;
                    if (rd_data == key_reg)
                    begin
                        res_next.was_present = 1'b1;
                        state_next           = ST_DONE;
                    end
                    else
                    begin
                        carry_next = rd_data;
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_FETCH;
                    end
                end
                else
                begin
                    res_next.entry_id    = rd_data;
                    res_next.entry_valid = 1'b1;
                    state_next           = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        carry_reg <= carry_next;
        idx_reg   <= idx_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mtfl_pkg::CNT_W'(mtfl_pkg::LIST_DEPTH))
        else $error("list count above capacity");

    a_check_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK |-> idx_reg < count_reg)
        else $error("compare beyond the end of the list");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(out_reg.was_present && out_reg.evicted))
        else $error("hit and eviction flagged together");

    a_done_publish: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && out_free |=> m_axis_tvalid && state_reg == ST_IDLE)
        else $error("finished result not moved to output");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE && state_reg != ST_FETCH |=> $stable(count_reg))
        else $error("count changed outside accept or append");

endmodule

>>> tb/recency_list_checker.sv
`timescale 1ns / 1ps

module recency_list_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // action[1:0], session_id[31:2], position[37:32], zero
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,  // entry_id, entry_valid, list_count, was_present, evicted
    output int          mismatches,
    output int          outstanding
);

    logic [mtfl_pkg::ID_W-1:0] recency_order [mtfl_pkg::LIST_DEPTH];
    int                        listed;
    mtfl_pkg::result_t         expected_replies [$];

    function automatic mtfl_pkg::result_t apply_request(logic [mtfl_pkg::ACT_W-1:0] act,
                                                        logic [mtfl_pkg::ID_W-1:0] id,
                                                        logic [mtfl_pkg::POS_W-1:0] pos);
        mtfl_pkg::result_t r;
        int                hit;
        int                upto;
        r = '0;
        case (act)
            mtfl_pkg::ACT_TOUCH:
            begin
                hit = -1;
                for (int k = 0; k < listed; k++)
                begin
                    if (hit < 0 && recency_order[k] == id)
                        hit = k;
                end
                if (hit >= 0)
                begin
                    r.was_present = 1'b1;
                    upto = hit;
                end
                else if (listed >= mtfl_pkg::LIST_DEPTH)
                begin
                    r.evicted = 1'b1;
                    upto = mtfl_pkg::LIST_DEPTH - 1;
                end
                else
                begin
                    upto = listed;
                    listed++;
                end
                for (int k = upto; k > 0; k--)
                    recency_order[k] = recency_order[k-1];
                recency_order[0] = id;
            end
            mtfl_pkg::ACT_READ:
            begin
                if (int'(pos) < listed)
                begin
                    r.entry_id    = recency_order[pos];
                    r.entry_valid = 1'b1;
                end
            end
            mtfl_pkg::ACT_CLEAR:
                listed = 0;
            default:
                ;
        endcase
        r.list_count = mtfl_pkg::LCNT_W'(listed);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mtfl_pkg::result_t got;
        mtfl_pkg::result_t want;
        mtfl_pkg::result_t pred;
        if (!rst_n)
        begin
            listed = 0;
            expected_replies.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                pred = apply_request(s_axis_tdata[1:0], s_axis_tdata[31:2],
                                     s_axis_tdata[37:32]);
                expected_replies.insert(expected_replies.size(), pred);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = mtfl_pkg::result_t'(m_axis_tdata);
                if (expected_replies.size() == 0)
                begin
                    $error("unexpected reply %0h", m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (got.entry_id !== want.entry_id)
                    begin
                        $error("entry_id: expected %0h, actual %0h", want.entry_id, got.entry_id);
                        mismatches++;
                    end
                    if (got.entry_valid !== want.entry_valid)
                    begin
                        $error("entry_valid: expected %0d, actual %0d",
                               want.entry_valid, got.entry_valid);
                        mismatches++;
                    end
                    if (got.list_count !== want.list_count)
                    begin
                        $error("list_count: expected %0d, actual %0d",
                               want.list_count, got.list_count);
                        mismatches++;
                    end
                    if (got.was_present !== want.was_present)
                    begin
                        $error("was_present: expected %0d, actual %0d",
                               want.was_present, got.was_present);
                        mismatches++;
                    end
                    if (got.evicted !== want.evicted)
                    begin
                        $error("evicted: expected %0d, actual %0d", want.evicted, got.evicted);
                        mismatches++;
                    end
                end
            end
            outstanding = expected_replies.size();
        end
    end

endmodule

>>> tb/tb_move_to_front_recency_list_core.sv
`timescale 1ns / 1ps

module tb_move_to_front_recency_list_core;

    localparam logic [mtfl_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int                         ID_POOL    = 90;
    localparam int                         PHASE_REQS = 410;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    int          mismatches;
    int          outstanding;
    int          tx_idle_pct = 38;
    int          rx_idle_pct = 51;
    logic [mtfl_pkg::ID_W-1:0] id_pool [ID_POOL];

    always #5 clk = ~clk;

    move_to_front_recency_list_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    recency_list_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_request(logic [mtfl_pkg::ACT_W-1:0] act, logic [mtfl_pkg::ID_W-1:0] id,
                                logic [mtfl_pkg::POS_W-1:0] pos);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, pos, id, act};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_random_request();
        int                        pick;
        logic [mtfl_pkg::ID_W-1:0] id;
        pick = $urandom_range(999);
        if ($urandom_range(99) < 75)
            id = id_pool[$urandom_range(ID_POOL - 1)];
        else
            id = mtfl_pkg::ID_W'($urandom());
        if (pick < 3)
            send_request(mtfl_pkg::ACT_CLEAR, id, mtfl_pkg::POS_W'($urandom()));
        else if (pick < 30)
            send_request(ACT_UNUSED, id, mtfl_pkg::POS_W'($urandom()));
        else if (pick < 640)
            send_request(mtfl_pkg::ACT_TOUCH, id, mtfl_pkg::POS_W'($urandom()));
        else
            send_request(mtfl_pkg::ACT_READ, id, mtfl_pkg::POS_W'($urandom()));
    endtask

    initial
    begin
        for (int k = 0; k < ID_POOL; k++)
            id_pool[k] = mtfl_pkg::ID_W'($urandom());
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(mtfl_pkg::ACT_READ, '0, '0);
        send_request(ACT_UNUSED, mtfl_pkg::ID_W'($urandom()), mtfl_pkg::POS_W'($urandom()));
        send_request(mtfl_pkg::ACT_CLEAR, '0, '0);
        send_request(mtfl_pkg::ACT_TOUCH, '0, '1);
        send_request(mtfl_pkg::ACT_TOUCH, '1, '0);
        send_request(mtfl_pkg::ACT_TOUCH, 30'h1555_5555, '0);
        send_request(mtfl_pkg::ACT_TOUCH, 30'h2AAA_AAAA, '0);
        send_request(mtfl_pkg::ACT_TOUCH, '0, '0);
        send_request(mtfl_pkg::ACT_TOUCH, '0, '0);
        send_request(mtfl_pkg::ACT_READ, '0, 6'd0);
        send_request(mtfl_pkg::ACT_READ, '0, 6'd3);
        send_request(mtfl_pkg::ACT_READ, '0, 6'd4);
        send_request(mtfl_pkg::ACT_READ, '1, '1);
        send_request(mtfl_pkg::ACT_TOUCH, '1, '0);
        send_request(mtfl_pkg::ACT_READ, '0, 6'd1);
        send_request(ACT_UNUSED, '1, '1);
        send_request(mtfl_pkg::ACT_CLEAR, '1, '1);
        send_request(mtfl_pkg::ACT_READ, '0, 6'd0);
        send_request(mtfl_pkg::ACT_TOUCH, 30'h2AAA_AAAA, '0);
        send_request(mtfl_pkg::ACT_READ, '0, 6'd0);

        repeat (PHASE_REQS) send_random_request();
        tx_idle_pct = 51;
        rx_idle_pct = 38;
        repeat (PHASE_REQS) send_random_request();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (PHASE_REQS) send_random_request();
        s_axis_tvalid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (2 * mtfl_pkg::LIST_DEPTH + 20) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
